/* sv/ple_pkg.sv */
package ple_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int POS_W    = 8;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int LEN_W    = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

/* sv/ple_cell.sv */
module ple_cell
	import ple_pkg::*;
#(
	parameter int IDX = 0,
	parameter int SW  = DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  cell_cmd_t     cmd,
	input  logic [SW-1:0] word,
	input  logic [SW-1:0] prev_data,
	input  logic [SW-1:0] next_data,
	output logic [SW-1:0] data,
	output logic [SW-1:0] tap
);

	localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

	logic [SW-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && (MyIdx > cmd.pos)) begin
			data_q <= prev_data;
		end else if (cmd.ins && (MyIdx == cmd.pos)) begin
			data_q <= word;
		end else if (cmd.del && (MyIdx >= cmd.pos)) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;
	assign tap  = (MyIdx == cmd.pos) ? data_q : '0;

endmodule

/* sv/positional_list_engine.sv */
// Channel   Handshake             Payload
// input     in_valid / in_ready   operation, position, item_data
// output    out_valid / out_ready status, read_data, list_length
//
// Every operation is decided and applied in the cycle it transfers; the
// whole row of cells shifts at once, so one item per cycle is sustained.
// Its result appears in the output register on the following cycle.
// An item is taken whenever the output register is empty or drains in
// the same cycle; a stalled output holds the input back.
// Reset clears the entry count and the output valid flag only.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [POS_W-1:0]    position,
	input  logic [WORD_W-1:0]   item_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [WORD_W-1:0]   read_data,
	output logic [LEN_W-1:0]    list_length
);

	localparam int SW   = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]   read_data_q;
	logic [LEN_W-1:0]    length_q;

	logic                accept;
	logic [CMPW-1:0]     pos_x;
	logic [CMPW-1:0]     cnt_x;
	logic                empty;
	logic                full;
	cell_cmd_t           cmd;
	logic [STATUS_W-1:0] st_next;
	logic [CW-1:0]       count_next;
	logic [SW-1:0]       word;
	logic [SW-1:0]       rd_word;

	logic [SW-1:0] cell_data [CAPACITY];
	logic [SW-1:0] cell_tap  [CAPACITY];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign pos_x    = CMPW'(position);
	assign cnt_x    = CMPW'(count_q);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CapCount);
	assign word     = item_data[SW-1:0];

	always_comb begin
		cmd        = '{ins: 1'b0, del: 1'b0, pos: position};
		st_next    = ST_BAD_POS;
		count_next = count_q;
		unique case (operation)
			OP_INSERT: begin
				if (empty) begin
					cmd.ins    = accept;
					cmd.pos    = '0;
					st_next    = ST_OK;
					count_next = count_q + 1'b1;
				end else if (pos_x <= cnt_x) begin
					if (full) begin
						st_next = ST_FULL;
					end else begin
						cmd.ins    = accept;
						st_next    = ST_OK;
						count_next = count_q + 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else if (pos_x < cnt_x) begin
					cmd.del    = accept;
					st_next    = ST_OK;
					count_next = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else if (pos_x < cnt_x) begin
					st_next = ST_OK;
				end
			end
			default: begin
				st_next = ST_BAD_POS;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [SW-1:0] prev_d;
		logic [SW-1:0] next_d;
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_p
			assign prev_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_n
			assign next_d = cell_data[i+1];
		end
		ple_cell #(
			.IDX(i),
			.SW (SW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.word     (word),
			.prev_data(prev_d),
			.next_data(next_d),
			.data     (cell_data[i]),
			.tap      (cell_tap[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_next;
			length_q <= LEN_W'(count_next);
			if ((operation == OP_READ) && (st_next == ST_OK)) begin
				read_data_q <= WORD_W'(rd_word);
			end else begin
				read_data_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_data   = read_data_q;
	assign list_length = length_q;

endmodule

/* sim/positional_list_engine_tb.sv */
`timescale 1ns / 1ps

module positional_list_engine_tb;
	import ple_pkg::*;

	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PER_PHASE = 200;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} list_op_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   rdata;
		logic [LEN_W-1:0]    len;
	} list_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     operation = OP_INSERT;
	logic [POS_W-1:0]    position = '0;
	logic [WORD_W-1:0]   item_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   read_data;
	logic [LEN_W-1:0]    list_length;

	list_op_t     op_backlog[$];
	list_result_t awaited_results[$];
	logic [WORD_W-1:0] list_words[CAPACITY_DEF];
	int list_len = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	positional_list_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.position(position),
		.item_data(item_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.read_data(read_data),
		.list_length(list_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word);
		list_result_t r;
		int i;
		r.status = ST_BAD_POS;
		r.rdata = '0;
		if (op == OP_INSERT) begin
			if (list_len == 0) begin
				list_words[0] = word;
				list_len = 1;
				r.status = ST_OK;
			end else if (pos <= list_len) begin
				if (list_len >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > pos; i--)
						list_words[i] = list_words[i-1];
					list_words[pos] = word;
					list_len++;
					r.status = ST_OK;
				end
			end
		end else if (op == OP_DELETE || op == OP_READ) begin
			if (list_len == 0) begin
				r.status = ST_EMPTY;
			end else if (pos < list_len) begin
				if (op == OP_DELETE) begin
					for (i = pos; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end else begin
					r.rdata = list_words[pos];
				end
				r.status = ST_OK;
			end
		end
		r.len = list_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	task automatic push_op(input logic [OP_W-1:0] op, input int pos, input logic [WORD_W-1:0] word);
		list_op_t t;
		t.op = op;
		t.pos = pos[POS_W-1:0];
		t.word = word;
		op_backlog.push_back(t);
	endtask

	// Runs of insert-heavy, delete-heavy and mixed traffic walk the list between
	// empty and full; most positions land near the live range.
	task automatic push_random_ops(input int n);
		int k;
		int trend;
		int roll;
		int pos;
		logic [OP_W-1:0] op;
		trend = 0;
		for (k = 0; k < n; k++) begin
			if (k % 30 == 0)
				trend = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			case (trend)
				0: op = (roll < 65) ? OP_INSERT : (roll < 80) ? OP_DELETE : OP_READ;
				1: op = (roll < 20) ? OP_INSERT : (roll < 70) ? OP_DELETE : OP_READ;
				default: op = (roll < 35) ? OP_INSERT : (roll < 60) ? OP_DELETE : OP_READ;
			endcase
			if ($urandom_range(0, 99) < 85)
				pos = $urandom_range(0, CAPACITY_DEF + 1);
			else
				pos = $urandom_range(0, 255);
			push_op(op, pos, $urandom);
		end
	endtask

	task automatic wait_drained();
		while (op_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Driver: a new item is presented only once the previous one transferred.
	always @(posedge clk) begin : driver
		list_op_t t;
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_results.push_back(apply_list_op(operation, position, item_data));
			if (!in_valid || in_ready) begin
				if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					t = op_backlog.pop_front();
					operation <= t.op;
					position <= t.pos;
					item_data <= t.word;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : monitor
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result transfer with nothing outstanding");
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (read_data !== want.rdata)
					report_mismatch($sformatf("read_data %h, expected %h", read_data,
						want.rdata));
				if (list_length !== want.len)
					report_mismatch($sformatf("list_length %0d, expected %0d", list_length,
						want.len));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 50;

		push_op(OP_READ, 0, 32'h0);
		push_op(OP_DELETE, 0, 32'h0);
		// An insert into an empty list lands at the front whatever the position.
		push_op(OP_INSERT, 200, 32'hFFFF_FFFF);
		push_op(OP_READ, 0, 32'h0);
		push_op(OP_INSERT, 2, 32'h1234_5678);
		push_op(OP_INSERT, 1, 32'h0000_0000);
		push_op(OP_INSERT, 0, 32'hA5A5_5A5A);
		push_op(OP_READ, 255, 32'h0);
		push_op(OP_UNKNOWN, 0, 32'hFFFF_FFFF);
		push_op(OP_DELETE, 1, 32'h0);
		push_op(OP_READ, 1, 32'h0);
		for (k = 0; k < CAPACITY_DEF - 2; k++)
			push_op(OP_INSERT, k + 1, $urandom);
		push_op(OP_INSERT, CAPACITY_DEF, 32'hDEAD_BEEF);
		push_op(OP_INSERT, CAPACITY_DEF + 1, 32'hDEAD_BEEF);
		push_op(OP_READ, CAPACITY_DEF - 1, 32'h0);
		push_op(OP_DELETE, CAPACITY_DEF - 1, 32'h0);
		push_op(OP_DELETE, 0, 32'h0);
		push_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 50;
		recv_idle_pct = 11;
		push_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_ops(RANDOM_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
